// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL that carries checks (the top-level queue).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("slpq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("slpq: next-cycle check failed");

`endif

// ----- src/slpq_pkg.sv -----
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types and codes for the sorted-list priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package slpq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_OUT_W  = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_PEEK   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic                      ins_en;
		logic                      pop_en;
		logic                      rem_en;
		logic signed [VALUE_W-1:0] operand;
	} slpq_ctrl_t;

endpackage

`default_nettype wire

// ----- src/slpq_cell.sv -----
// ----------------------------------------------------------------------------
// slpq_cell
// One slot of the sorted row: holds an entry, compares it with the operand
// and takes a value from its left or right neighbour on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module slpq_cell
	import slpq_pkg::*;
(
	input  wire logic                      clk,
	input  wire slpq_ctrl_t                ctrl,
	input  wire logic                      occupied,
	input  wire logic                      left_ge,
	input  wire logic signed [VALUE_W-1:0] left_val,
	input  wire logic signed [VALUE_W-1:0] right_val,
	output logic                           ge,
	output logic                           match,
	output logic signed [VALUE_W-1:0]      val
);

	logic signed [VALUE_W-1:0] entry_q;

	// An empty slot counts as larger than anything, so ge rises once along the row.
	assign ge    = !occupied || ($signed(entry_q) >= $signed(ctrl.operand));
	assign match = occupied && (entry_q == ctrl.operand);
	assign val   = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (left_ge) begin
				entry_q <= left_val;
			end else if (ge) begin
				entry_q <= ctrl.operand;
			end
		end else if (ctrl.pop_en || (ctrl.rem_en && ge)) begin
			entry_q <= right_val;
		end
	end

endmodule

`default_nettype wire

// ----- src/sorted_list_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_list_priority_queue
// Ascending store of signed values in a row of compare-and-shift cells,
// serving insert, pop smallest, remove matching value and peek smallest.
// ----------------------------------------------------------------------------
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | operation, operand_value
//   out     | out_valid/out_stall| result_value, status, entry_count, is_empty
//
// Every cell compares and shifts in parallel, and the
// result lands in the output register on the accepting edge.
// A new beat is taken each cycle while the output register is free or drained.
// Reset clears the count and output valid; cell contents are left as they are.
// A stalled output holds its beat and stalls the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_priority_queue
	import slpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [OP_W-1:0]               operation,
	input  wire logic signed [VALUE_W-1:0]     operand_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [VALUE_W-1:0]          result_value,
	output logic [STATUS_W-1:0]                status,
	output logic [COUNT_OUT_W-1:0]             entry_count,
	output logic                               is_empty
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_nxt;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] result_value_q;
	logic [STATUS_W-1:0]       status_q;
	logic [COUNT_OUT_W-1:0]    entry_count_q;
	logic                      is_empty_q;

	logic                      in_acc;
	logic                      full;
	logic                      empty;
	logic                      found;
	logic signed [VALUE_W-1:0] res_val;
	logic [STATUS_W-1:0]       res_status;
	slpq_ctrl_t                ctrl;

	logic [CAPACITY-1:0]       occ;
	logic [CAPACITY-1:0]       ge;
	logic [CAPACITY-1:0]       match;
	logic signed [VALUE_W-1:0] cell_val [CAPACITY];

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign found    = |match;

	always_comb begin
		ctrl.ins_en  = 1'b0;
		ctrl.pop_en  = 1'b0;
		ctrl.rem_en  = 1'b0;
		ctrl.operand = operand_value;
		res_val      = '0;
		res_status   = ST_OK;
		count_nxt    = count_q;
		case (operation)
			OP_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					ctrl.ins_en = in_acc;
					count_nxt   = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					res_status = ST_MISSING;
				end else begin
					ctrl.pop_en = in_acc;
					res_val     = cell_val[0];
					count_nxt   = count_q - 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!found) begin
					res_status = ST_MISSING;
				end else begin
					ctrl.rem_en = in_acc;
					count_nxt   = count_q - 1'b1;
				end
			end
			OP_PEEK: begin
				if (empty) begin
					res_status = ST_MISSING;
				end else begin
					res_val = cell_val[0];
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      l_ge;
		logic signed [VALUE_W-1:0] l_val;
		logic signed [VALUE_W-1:0] r_val;

		assign occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign l_ge  = 1'b0;
			assign l_val = operand_value;
		end else begin : g_mid
			assign l_ge  = ge[i-1];
			assign l_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_val = cell_val[i];
		end else begin : g_inner
			assign r_val = cell_val[i+1];
		end

		slpq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occ[i]),
			.left_ge  (l_ge),
			.left_val (l_val),
			.right_val(r_val),
			.ge       (ge[i]),
			.match    (match[i]),
			.val      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_value_q <= res_val;
			status_q       <= res_status;
			entry_count_q  <= COUNT_OUT_W'(count_nxt);
			is_empty_q     <= (count_nxt == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;
	assign is_empty     = is_empty_q;

	`SLPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`SLPQ_ASSERT_NXT(a_ins_grows, clk, arst_n, ctrl.ins_en, count_q == CW'($past(count_q) + 1'b1))
	`SLPQ_ASSERT_NXT(a_acc_shows, clk, arst_n, in_acc, out_valid_q)

endmodule

`default_nettype wire

// ----- tb/slpq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slpq_checker
// Watches both channels of the sorted-list priority queue, tracks the store
// contents on every accepted operation and compares each result beat, field
// by field, against the oldest predicted one.
// ----------------------------------------------------------------------------

module slpq_checker
	import slpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [OP_W-1:0]           operation,
	input  logic signed [VALUE_W-1:0] operand_value,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [VALUE_W-1:0] result_value,
	input  logic [STATUS_W-1:0]       status,
	input  logic [COUNT_OUT_W-1:0]    entry_count,
	input  logic                      is_empty,
	output int                        pending_results,
	output int                        fail_count
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
		logic [COUNT_OUT_W-1:0]    count;
		logic                      empty;
	} queue_result_t;

	logic signed [VALUE_W-1:0] ordered_values[$];
	queue_result_t             predicted_results[$];
	int                        fail_total = 0;

	assign fail_count = fail_total;

	// Apply one operation to the shadow store and return the result it gives.
	function automatic queue_result_t apply_op(input logic [OP_W-1:0] op,
			input logic signed [VALUE_W-1:0] v);
		queue_result_t r;
		int pos;
		r.value  = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (ordered_values.size() >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// place ahead of the first entry >= v, so a new value goes ahead of any equal ones
					pos = 0;
					while (pos < ordered_values.size() && ordered_values[pos] < v)
						pos++;
					ordered_values.insert(pos, v);
				end
			end
			OP_POP: begin
				if (ordered_values.size() == 0)
					r.status = ST_MISSING;
				else
					r.value = ordered_values.pop_front();
			end
			OP_REMOVE: begin
				pos = 0;
				while (pos < ordered_values.size() && ordered_values[pos] != v)
					pos++;
				if (pos == ordered_values.size())
					r.status = ST_MISSING;
				else
					ordered_values.delete(pos);
			end
			OP_PEEK: begin
				if (ordered_values.size() == 0)
					r.status = ST_MISSING;
				else
					r.value = ordered_values[0];
			end
		endcase
		r.count = COUNT_OUT_W'(ordered_values.size());
		r.empty = (ordered_values.size() == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			ordered_values.delete();
			predicted_results.delete();
			pending_results <= 0;
		end else begin
			// take the result beat first: it can only belong to an earlier operation
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (predicted_results.size() == 0) begin
					$error("result beat with no operation outstanding");
					fail_total++;
				end else begin
					want = predicted_results.pop_front();
					if (result_value !== want.value) begin
						$error("result_value: expected %0d, got %0d", want.value, result_value);
						fail_total++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_total++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
						fail_total++;
					end
					if (is_empty !== want.empty) begin
						$error("is_empty: expected %0d, got %0d", want.empty, is_empty);
						fail_total++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				predicted_results.push_back(apply_op(operation, operand_value));
			pending_results <= predicted_results.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, pop, remove and peek operations into the sorted-list
// priority queue with bursty traffic and a stalling receiver; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------

module tb_top;
	import slpq_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

	logic                      clk;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_stall;
	logic [OP_W-1:0]           operation     = OP_PEEK;
	logic signed [VALUE_W-1:0] operand_value = '0;
	logic                      out_valid;
	logic                      out_stall     = 1'b0;
	logic signed [VALUE_W-1:0] result_value;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_OUT_W-1:0]    entry_count;
	logic                      is_empty;

	int pending_results;
	int fail_count;
	int cycle_count = 0;

	logic signed [VALUE_W-1:0] recent_inserts[$];

	sorted_list_priority_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value),
		.status        (status),
		.entry_count   (entry_count),
		.is_empty      (is_empty)
	);

	slpq_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.operand_value   (operand_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_value    (result_value),
		.status          (status),
		.entry_count     (entry_count),
		.is_empty        (is_empty),
		.pending_results (pending_results),
		.fail_count      (fail_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_list_priority_queue: mismatch");
			$finish;
		end
	end

	// Receiver: phases of no stall, scattered stalls and long stall runs.
	int unsigned stall_mode = 0;
	int unsigned phase_left = 0;
	int unsigned hold_left  = 0;

	always @(posedge clk) begin
		if (phase_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			phase_left = $urandom_range(20, 200);
		end else begin
			phase_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (hold_left == 0) begin
					hold_left = $urandom_range(1, 12);
					out_stall <= ~out_stall;
				end else begin
					hold_left--;
				end
			end
		endcase
	end

	// Present one beat and hold it until accepted.
	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
		in_valid      <= 1'b1;
		operation     <= op;
		operand_value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (op == OP_INSERT) begin
			recent_inserts.push_back(v);
			if (recent_inserts.size() > 32)
				void'(recent_inserts.pop_front());
		end
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every outstanding result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 8)) - 32'd4;
			4, 5:       return $urandom;
			6: begin
				case ($urandom_range(0, 3))
					0:       return VALUE_MAX;
					1:       return VALUE_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: begin
				if (recent_inserts.size() == 0)
					return $urandom;
				return recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
			end
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input traffic_mix_t mix);
		int roll;
		int ins_cut;
		int pop_cut;
		int rem_cut;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				ins_cut = 70; pop_cut = 80; rem_cut = 90;
			end
			MIX_DRAIN: begin
				ins_cut = 15; pop_cut = 55; rem_cut = 85;
			end
			default: begin
				ins_cut = 25; pop_cut = 50; rem_cut = 75;
			end
		endcase
		if (roll < ins_cut)
			return OP_INSERT;
		if (roll < pop_cut)
			return OP_POP;
		if (roll < rem_cut)
			return OP_REMOVE;
		return OP_PEEK;
	endfunction

	task automatic send_random(input traffic_mix_t mix);
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] v;
		op = pick_op(mix);
		// removes mostly aim at recently inserted values so they often hit
		if (op == OP_REMOVE && recent_inserts.size() != 0 && $urandom_range(0, 9) < 6)
			v = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
		else
			v = pick_value();
		send_item(op, v);
	endtask

	initial begin
		int           sent;
		int           burst;
		traffic_mix_t mix;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// operations on an empty store
		send_item(OP_PEEK, '0);
		send_item(OP_POP, VALUE_MAX);
		send_item(OP_REMOVE, 32'sd7);
		// extremes, zero, minus one and a duplicate
		send_item(OP_INSERT, VALUE_MAX);
		send_item(OP_INSERT, VALUE_MIN);
		send_item(OP_INSERT, '0);
		send_item(OP_INSERT, '1);
		send_item(OP_INSERT, '0);
		send_item(OP_PEEK, '1);
		send_item(OP_REMOVE, 32'sd5);
		send_item(OP_REMOVE, '0);
		send_item(OP_POP, '0);
		// fill to capacity, then insert into a full store
		repeat (14) send_item(OP_INSERT, $urandom);
		send_item(OP_REMOVE, VALUE_MAX);
		send_item(OP_PEEK, '0);
		drain_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			mix   = traffic_mix_t'($urandom_range(0, 2));
			repeat (burst) begin
				send_random(mix);
				sent++;
				if (sent == RANDOM_ITEMS / 2)
					drain_results();
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 8));
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_list_priority_queue: match");
		else
			$display("sorted_list_priority_queue: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/slpq_pkg.sv
src/slpq_cell.sv
src/sorted_list_priority_queue.sv
tb/slpq_checker.sv
tb/tb_top.sv
